// File: sv/lidar_avoid_heading_steer_top_assert.svh
// assertion macros for the checker file
`ifndef LIDAR_AVOID_HEADING_STEER_TOP_ASSERT_SVH
`define LIDAR_AVOID_HEADING_STEER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define LAHS_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define LAHS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also runs through reset
`define LAHS_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/lahs_pkg.sv
// ----------------------------------------------------------------------------
// lahs_pkg
// Types, constants and helpers of the lidar avoid / heading steer block.
// ----------------------------------------------------------------------------
package lahs_pkg;

  localparam int RANGE_W    = 16;
  localparam int HEAD_W     = 16;
  localparam int CNT_W      = 11;
  localparam int SUM_W      = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_THR   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DANGER_THR = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AVOID      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_SPEED  = 4'd7;

  // register reset values
  localparam logic [15:0]        RST_SIDE_THR   = 16'd650;
  localparam logic [15:0]        RST_DANGER_THR = 16'd450;
  localparam logic [19:0]        RST_KP_GAIN    = 20'd17920;
  localparam logic [19:0]        RST_KI_GAIN    = 20'd0;
  localparam logic [19:0]        RST_KD_GAIN    = 20'd179200;
  localparam logic [8:0]         RST_AVOID      = 9'd60;
  localparam logic signed [9:0]  RST_OFFSET     = 10'sd60;
  localparam logic signed [8:0]  RST_FWD_SPEED  = 9'sd120;

  // frame bytes
  localparam logic [7:0] FRAME_SOF  = 8'hF8;
  localparam logic [7:0] FRAME_LEN  = 8'h04;
  localparam logic [7:0] FRAME_EOF  = 8'h8F;

  // speeds and limits
  localparam logic signed [15:0] PAUSE_SPEED = -16'sd150;
  localparam logic signed [15:0] BACK_SPEED  = 16'sd100;
  localparam logic signed [8:0]  SPEED_LIM   = 9'sd180;

  // 6/5 as multiply by 6*ceil(2^18/5) then shift by 18, exact for magnitudes up to 2^15
  localparam logic [18:0] PAUSE_RECIP = 19'd314574;
  localparam int          PAUSE_SHIFT = 18;

  localparam int GAIN_SHIFT = 21;

  typedef struct packed {
    logic [15:0]       side_threshold;
    logic [15:0]       danger_threshold;
    logic [19:0]       kp_gain;
    logic [19:0]       ki_gain;
    logic [19:0]       kd_gain;
    logic [8:0]        avoid_steer;
    logic signed [9:0] steer_offset;
    logic signed [8:0] forward_speed;
  } cfg_t;

  // one finished scan, as the front hands it over
  typedef struct packed {
    logic                     front_near;
    logic                     left_near;
    logic                     right_near;
    logic signed [HEAD_W-1:0] heading;
  } rec_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v[16] != v[15]) begin
      return v[16] ? 16'sh8000 : 16'sh7FFF;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

endpackage

// File: sv/lahs_ifs.sv
// ----------------------------------------------------------------------------
// lahs_ifs
// Valid/ready channels of the lidar avoid / heading steer block.
// ----------------------------------------------------------------------------
interface lahs_in_if import lahs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [RANGE_W-1:0]       range_sample;
  logic signed [HEAD_W-1:0] heading;
  logic                     scan_end;

  modport source (output valid, range_sample, heading, scan_end, input ready);
  modport sink   (input valid, range_sample, heading, scan_end, output ready);
endinterface

interface lahs_out_if import lahs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, frame_byte, frame_last, input ready);
  modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

interface lahs_cfg_if import lahs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/lahs_front.sv
// ----------------------------------------------------------------------------
// lahs_front
// Takes range samples, builds the side sums and the front flag, and hands one
// record per scan to the queue.
// ----------------------------------------------------------------------------
module lahs_front import lahs_pkg::*; #(
  parameter int SCAN_LEN    = 1080,
  parameter int SIDE_WINDOW = 120,
  parameter int FRONT_HALF  = 30
) (
  input  logic       clk,
  input  logic       rst_n,
  lahs_in_if.sink    in_ch,
  input  cfg_t       cfg,
  input  q_stat_t    q_stat,
  output logic       push,
  output rec_t       push_rec
);

  localparam logic [CNT_W-1:0] LEFT_END  = CNT_W'(SIDE_WINDOW);
  localparam logic [CNT_W-1:0] RIGHT_BEG = CNT_W'(SCAN_LEN - SIDE_WINDOW);
  localparam logic [CNT_W-1:0] RIGHT_END = CNT_W'(SCAN_LEN);
  localparam logic [CNT_W-1:0] FRONT_BEG = CNT_W'(SCAN_LEN / 2 - FRONT_HALF);
  localparam logic [CNT_W-1:0] FRONT_END = CNT_W'(SCAN_LEN / 2 + FRONT_HALF);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] lsum_r, lsum_nxt;
  logic [SUM_W-1:0] rsum_r, rsum_nxt;
  logic             near_r, near_nxt;

  logic [SUM_W-1:0] lsum_add, rsum_add;
  logic             near_add;
  logic [31:0]      lim_full;
  logic [SUM_W-1:0] lim;
  logic             fire;
  logic             in_left, in_right, in_front;

  assign in_ch.ready = !q_stat.full;
  assign fire        = in_ch.valid && in_ch.ready;

  assign in_left  = cnt_r < LEFT_END;
  assign in_right = (cnt_r >= RIGHT_BEG) && (cnt_r < RIGHT_END);
  assign in_front = (cnt_r >= FRONT_BEG) && (cnt_r < FRONT_END);

  assign lsum_add = in_left  ? SUM_W'(lsum_r + {8'd0, in_ch.range_sample}) : lsum_r;
  assign rsum_add = in_right ? SUM_W'(rsum_r + {8'd0, in_ch.range_sample}) : rsum_r;
  assign near_add = near_r || (in_front && (in_ch.range_sample != '0)
                               && (in_ch.range_sample < cfg.danger_threshold));

  // side limit is window length times the mean threshold
  assign lim_full = 32'(SIDE_WINDOW) * {16'd0, cfg.side_threshold};
  assign lim      = lim_full[SUM_W-1:0];

  assign push               = fire && in_ch.scan_end;
  assign push_rec.front_near = near_add;
  assign push_rec.left_near  = lsum_add < lim;
  assign push_rec.right_near = rsum_add < lim;
  assign push_rec.heading    = in_ch.heading;

  always_comb begin
    cnt_nxt  = cnt_r;
    lsum_nxt = lsum_r;
    rsum_nxt = rsum_r;
    near_nxt = near_r;
    if (fire) begin
      if (in_ch.scan_end) begin
        cnt_nxt  = '0;
        lsum_nxt = '0;
        rsum_nxt = '0;
        near_nxt = 1'b0;
      end else begin
        cnt_nxt  = (cnt_r != CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
        lsum_nxt = lsum_add;
        rsum_nxt = rsum_add;
        near_nxt = near_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      lsum_r <= '0;
      rsum_r <= '0;
      near_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      lsum_r <= lsum_nxt;
      rsum_r <= rsum_nxt;
      near_r <= near_nxt;
    end
  end

endmodule

// File: sv/lahs_fifo.sv
// ----------------------------------------------------------------------------
// lahs_fifo
// Short queue of scan records between the front and the back.
// ----------------------------------------------------------------------------
module lahs_fifo import lahs_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  rec_t    push_rec,
  input  logic    pop,
  output rec_t    head_rec,
  output q_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_Q-1:0] CNT_FULL = CNT_Q'(DEPTH);

  rec_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_Q-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_stat.empty = count_r == '0;
  assign q_stat.full  = count_r == CNT_FULL;
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_rec     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: sv/lahs_back.sv
// ----------------------------------------------------------------------------
// lahs_back
// Per scan: drive mode, heading loop, avoidance and trim, then the seven byte
// command frame.
// ----------------------------------------------------------------------------
module lahs_back import lahs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  q_stat_t   q_stat,
  input  rec_t      head_rec,
  output logic      pop,
  lahs_out_if.source out_ch
);

  localparam int ACC_W = 54;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_PAUSE = 4'd2;
  localparam logic [3:0] S_M1    = 4'd3;
  localparam logic [3:0] S_M2    = 4'd4;
  localparam logic [3:0] S_M3    = 4'd5;
  localparam logic [3:0] S_M4    = 4'd6;
  localparam logic [3:0] S_QUO   = 4'd7;
  localparam logic [3:0] S_STEER = 4'd8;
  localparam logic [3:0] S_TRIM  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  localparam logic [2:0] B_SOF   = 3'd0;
  localparam logic [2:0] B_LEN   = 3'd1;
  localparam logic [2:0] B_STL   = 3'd2;
  localparam logic [2:0] B_STH   = 3'd3;
  localparam logic [2:0] B_SPL   = 3'd4;
  localparam logic [2:0] B_SPH   = 3'd5;
  localparam logic [2:0] B_EOF   = 3'd6;

  localparam logic MODE_FORWARD  = 1'b0;
  localparam logic MODE_BACKWARD = 1'b1;

  logic [3:0]              state_r, state_nxt;
  rec_t                    rec_r;
  logic                    mode_r;
  logic                    started_r;
  logic signed [15:0]      prev_hd_r;
  logic signed [16:0]      prev_err_r;
  logic signed [31:0]      err_tot_r;
  logic signed [15:0]      prev_steer_r;

  logic signed [16:0]      e_r;
  logic signed [17:0]      d_r;
  logic signed [31:0]      et_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] prod_r;
  logic [34:0]             pmag_r;
  logic                    psign_r;
  logic signed [15:0]      q_r;
  logic signed [15:0]      steer_r;
  logic signed [15:0]      speed_r;
  logic signed [15:0]      osteer_r;
  logic [2:0]              idx_r;

  logic                    ov_r;
  logic [7:0]              obyte_r;
  logic                    olast_r;

  // loop terms, with the first run after reset starting from zero error
  logic signed [16:0]      e_raw;
  logic signed [16:0]      pe_eff;
  logic signed [17:0]      d_raw;
  logic signed [31:0]      et_eff;
  logic signed [20:0]      kp_s, ki_s, kd_s;
  logic signed [37:0]      mul_p;
  logic signed [52:0]      mul_i;
  logic signed [38:0]      mul_d;
  logic [ACC_W-1:0]        mag;
  logic [32:0]             sh;
  logic signed [15:0]      q_val;
  logic [16:0]             qm;
  logic signed [15:0]      pause_val;
  logic [15:0]             steer_abs;
  logic signed [16:0]      av;
  logic signed [15:0]      fwd_speed;
  logic                    can_load;
  logic [7:0]              byte_sel;

  assign pop = (state_r == S_IDLE) && !q_stat.empty;

  assign e_raw  = started_r ? ({prev_hd_r[15], prev_hd_r} - {rec_r.heading[15], rec_r.heading})
                            : 17'sd0;
  assign pe_eff = started_r ? prev_err_r : 17'sd0;
  assign et_eff = started_r ? err_tot_r : 32'sd0;
  assign d_raw  = {e_raw[16], e_raw} - {pe_eff[16], pe_eff};

  assign kp_s  = $signed({1'b0, cfg.kp_gain});
  assign ki_s  = $signed({1'b0, cfg.ki_gain});
  assign kd_s  = $signed({1'b0, cfg.kd_gain});
  assign mul_p = kp_s * e_r;
  assign mul_i = ki_s * et_r;
  assign mul_d = kd_s * d_r;

  // truncation toward zero: shift the magnitude, then restore the sign
  assign mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign sh  = mag[ACC_W-1:GAIN_SHIFT];
  always_comb begin
    if (acc_r[ACC_W-1]) begin
      q_val = (sh > 33'd32768) ? 16'sh8000 : $signed(~sh[15:0] + 16'd1);
    end else begin
      q_val = (sh > 33'd32767) ? 16'sh7FFF : $signed(sh[15:0]);
    end
  end

  assign steer_abs = prev_steer_r[15] ? 16'(~prev_steer_r + 16'sd1) : prev_steer_r;
  assign qm        = pmag_r[34:PAUSE_SHIFT];
  always_comb begin
    if (psign_r) begin
      pause_val = (qm > 17'd32768) ? 16'sh8000 : $signed(~qm[15:0] + 16'd1);
    end else begin
      pause_val = (qm > 17'd32767) ? 16'sh7FFF : $signed(qm[15:0]);
    end
  end

  always_comb begin
    if (rec_r.left_near) begin
      av = -$signed({8'd0, cfg.avoid_steer});
    end else if (rec_r.right_near) begin
      av = $signed({8'd0, cfg.avoid_steer});
    end else begin
      av = 17'sd0;
    end
  end

  always_comb begin
    if (cfg.forward_speed > SPEED_LIM) begin
      fwd_speed = {{7{SPEED_LIM[8]}}, SPEED_LIM};
    end else if (cfg.forward_speed < -SPEED_LIM) begin
      fwd_speed = -{{7{SPEED_LIM[8]}}, SPEED_LIM};
    end else begin
      fwd_speed = {{7{cfg.forward_speed[8]}}, cfg.forward_speed};
    end
  end

  always_comb begin
    case (idx_r)
      B_SOF:   byte_sel = FRAME_SOF;
      B_LEN:   byte_sel = FRAME_LEN;
      B_STL:   byte_sel = osteer_r[7:0];
      B_STH:   byte_sel = osteer_r[15:8];
      B_SPL:   byte_sel = speed_r[7:0];
      B_SPH:   byte_sel = speed_r[15:8];
      B_EOF:   byte_sel = FRAME_EOF;
      default: byte_sel = FRAME_EOF;
    endcase
  end

  assign can_load = !ov_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (!q_stat.empty) state_nxt = S_PREP;
      S_PREP: begin
        if (mode_r == MODE_BACKWARD) begin
          state_nxt = S_TRIM;
        end else if (rec_r.front_near) begin
          state_nxt = S_PAUSE;
        end else begin
          state_nxt = S_M1;
        end
      end
      S_PAUSE: state_nxt = S_TRIM;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = S_QUO;
      S_QUO:   state_nxt = S_STEER;
      S_STEER: state_nxt = S_TRIM;
      S_TRIM:  state_nxt = S_EMIT;
      S_EMIT:  if (can_load && idx_r == B_EOF) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_FORWARD;
      started_r    <= 1'b0;
      prev_hd_r    <= '0;
      prev_err_r   <= '0;
      err_tot_r    <= '0;
      prev_steer_r <= '0;
      ov_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_PREP: begin
          if (mode_r == MODE_BACKWARD) begin
            mode_r <= MODE_FORWARD;
          end else if (rec_r.front_near) begin
            mode_r <= MODE_BACKWARD;
          end
        end
        S_STEER: begin
          err_tot_r  <= sat32({et_r[31], et_r} + {{16{e_r[16]}}, e_r});
          prev_err_r <= e_r;
          prev_hd_r  <= rec_r.heading;
          started_r  <= 1'b1;
        end
        S_TRIM:  prev_steer_r <= steer_r;
        default: ;
      endcase
      if (state_r == S_EMIT && can_load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) rec_r <= head_rec;
      end
      S_PREP: begin
        e_r     <= e_raw;
        d_r     <= d_raw;
        et_r    <= et_eff;
        pmag_r  <= 35'(steer_abs * PAUSE_RECIP);
        psign_r <= prev_steer_r[15];
        if (mode_r == MODE_BACKWARD) begin
          steer_r <= 16'sd0;
          speed_r <= BACK_SPEED;
        end else if (rec_r.front_near) begin
          speed_r <= PAUSE_SPEED;
        end else begin
          speed_r <= fwd_speed;
        end
      end
      S_PAUSE: steer_r <= pause_val;
      S_M1:    acc_r   <= {{(ACC_W-38){mul_p[37]}}, mul_p};
      S_M2:    prod_r  <= {{(ACC_W-53){mul_i[52]}}, mul_i};
      S_M3: begin
        acc_r  <= acc_r + prod_r;
        prod_r <= {{(ACC_W-39){mul_d[38]}}, mul_d};
      end
      S_M4:    acc_r   <= acc_r + prod_r;
      S_QUO:   q_r     <= q_val;
      S_STEER: steer_r <= sat16({q_r[15], q_r} + av);
      S_TRIM: begin
        osteer_r <= sat16({steer_r[15], steer_r} + {{7{cfg.steer_offset[9]}}, cfg.steer_offset});
        idx_r    <= B_SOF;
      end
      S_EMIT: begin
        if (can_load) begin
          obyte_r <= byte_sel;
          olast_r <= idx_r == B_EOF;
          idx_r   <= idx_r + 3'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.frame_byte = obyte_r;
  assign out_ch.frame_last = olast_r;

endmodule

// File: sv/lidar_avoid_heading_steer_top.sv
// ----------------------------------------------------------------------------
// lidar_avoid_heading_steer_top
// Laser scan avoidance and heading-rate steering with framed command output.
// ----------------------------------------------------------------------------
// in_ch takes one range sample per word; scan_end marks the last sample of a
// scan and carries the heading used for that scan's control step.
// out_ch gives seven bytes per scan: F8, 04, steer LE16, speed LE16, 8F, with
// frame_last on the final byte. cfg_ch writes one register per word and is
// always ready; write only while no scan is in flight.
// Samples are taken one per cycle. A scan_end word is queued as one record;
// in_ch.ready drops only while that queue is full.
// The back end runs one record at a time: on the loop path it steps through
// PREP, the multiply-accumulate states M1 to M4, QUO, STEER and TRIM before
// the first byte (PREP goes to TRIM in backward mode, or via PAUSE on a near
// front), then the byte sequencer gives one byte per cycle while out_ch.ready is high.
// A stall on out_ch holds the current byte; the front keeps taking samples
// and queues up to QUEUE_DEPTH finished scans.
// Reset clears all sums, the drive mode, the loop history and the queue, and
// loads the register defaults.
// ----------------------------------------------------------------------------
module lidar_avoid_heading_steer_top import lahs_pkg::*; #(
  parameter int SCAN_LEN    = 1080,
  parameter int SIDE_WINDOW = 120,
  parameter int FRONT_HALF  = 30,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  lahs_in_if.sink    in_ch,
  lahs_out_if.source out_ch,
  lahs_cfg_if.sink   cfg_ch
);

  cfg_t    cfg_r;
  q_stat_t q_stat;
  logic    push;
  rec_t    push_rec;
  logic    pop;
  rec_t    head_rec;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.side_threshold   <= RST_SIDE_THR;
      cfg_r.danger_threshold <= RST_DANGER_THR;
      cfg_r.kp_gain          <= RST_KP_GAIN;
      cfg_r.ki_gain          <= RST_KI_GAIN;
      cfg_r.kd_gain          <= RST_KD_GAIN;
      cfg_r.avoid_steer      <= RST_AVOID;
      cfg_r.steer_offset     <= RST_OFFSET;
      cfg_r.forward_speed    <= RST_FWD_SPEED;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_SIDE_THR:   cfg_r.side_threshold   <= cfg_ch.data[15:0];
        REG_DANGER_THR: cfg_r.danger_threshold <= cfg_ch.data[15:0];
        REG_KP_GAIN:    cfg_r.kp_gain          <= cfg_ch.data;
        REG_KI_GAIN:    cfg_r.ki_gain          <= cfg_ch.data;
        REG_KD_GAIN:    cfg_r.kd_gain          <= cfg_ch.data;
        REG_AVOID:      cfg_r.avoid_steer      <= cfg_ch.data[8:0];
        REG_OFFSET:     cfg_r.steer_offset     <= $signed(cfg_ch.data[9:0]);
        REG_FWD_SPEED:  cfg_r.forward_speed    <= $signed(cfg_ch.data[8:0]);
        default: ;
      endcase
    end
  end

  lahs_front #(
    .SCAN_LEN    (SCAN_LEN),
    .SIDE_WINDOW (SIDE_WINDOW),
    .FRONT_HALF  (FRONT_HALF)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  lahs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .q_stat   (q_stat)
  );

  lahs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_stat   (q_stat),
    .head_rec (head_rec),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// File: sv/lahs_checker.sv
// ----------------------------------------------------------------------------
// lahs_checker
// Port-level checks of the command frame stream.
// ----------------------------------------------------------------------------
`include "lidar_avoid_heading_steer_top_assert.svh"

module lahs_checker import lahs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] frame_byte,
  input logic       frame_last
);

  // a stalled byte holds
  `LAHS_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(frame_byte) && $stable(frame_last), "stalled output word changed")

  // bytes of one frame follow without gaps
  `LAHS_NEXT(a_no_gap, out_valid && out_ready && !frame_last, out_valid, "gap inside a frame")

  // after a frame ends the next word opens a frame
  `LAHS_NEXT(a_next_sof, out_valid && out_ready && frame_last, !out_valid || (frame_byte == FRAME_SOF && !frame_last), "frame does not start with sof")

  // nothing is offered straight out of reset
  `LAHS_NEXT_ALWAYS(a_rst_idle, !rst_n, !out_valid, "output valid after reset")

endmodule

bind lidar_avoid_heading_steer_top lahs_checker u_lahs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .frame_byte (out_ch.frame_byte),
  .frame_last (out_ch.frame_last)
);
